/* hdl/utf8l1_pkg.sv */
// Shared constants and types for the UTF-8 to Latin-1 decoder.
// No dependencies; imported by the core and by its checker.
`default_nettype none

package utf8l1_pkg;

  localparam int BYTE_W      = 8;
  localparam int CODE_W      = 16;
  localparam int MAX_RESULTS = 3;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [CODE_W-1:0] REPL_RESET = 16'd63;

  // Byte class masks and patterns.
  localparam logic [7:0] MASK_TOP2  = 8'hC0;
  localparam logic [7:0] CONT_PAT   = 8'h80;
  localparam logic [7:0] MASK_TOP3  = 8'hE0;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] MASK_TOP4  = 8'hF0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD2_BITS = 8'h1F;
  localparam logic [7:0] CONT_BITS  = 8'h3F;
  localparam logic [7:0] LEAD3_BITS = 8'h0F;
  localparam logic [CODE_W-1:0] LATIN1_MAX = 16'h00FF;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [CNT_W-1:0]  cnt_t;

endpackage

`default_nettype wire

/* hdl/utf8_to_latin1_decoder_core.sv */
// UTF-8 to Latin-1 decoder core: input register, single-pass decode, result queue.
// Depends on utf8l1_pkg.
//
// Channel   Dir  Signals                         Contents
// s_axis    in   tvalid tready tdata[7:0] tlast  tdata: in_byte; tlast: end_of_text
// m_axis    out  tvalid tready tdata[15:0]       tdata: code
//                tuser[1:0] tlast                tuser: was_replaced, run_last; tlast: text_last
// cfg       in   valid ready data[15:0]          replacement_code
//
// A byte that yields at most one character passes at one byte per cycle while m_axis
// is not stalled, through the input register and then the result register. A byte that
// yields r characters takes r transfers on the result port, and the decode takes no new
// byte until the last of them is being handed over; the single result port sets that limit.
// Reset (rst, synchronous) empties the input register and the result queue, drops any
// pending bytes and sets the replacement code to 63.
// A stall on m_axis holds the results in place; one more byte waits in the input register.
`default_nettype none

module utf8_to_latin1_decoder_core
  import utf8l1_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // Input byte stream.
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [7:0]        s_axis_tdata,   // [7:0] in_byte
  input  wire logic              s_axis_tlast,   // end_of_text
  // Decoded characters.
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [15:0]            m_axis_tdata,   // [15:0] code
  output logic [1:0]             m_axis_tuser,   // [0] was_replaced, [1] run_last
  output logic                   m_axis_tlast,   // text_last
  // Replacement code register.
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [15:0]       cfg_data
);

  // Configuration register. Writes must come only while the block is idle (not enforced).
  code_t repl_code;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      repl_code <= REPL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      repl_code <= cfg_data;
    end
  end

  // Input register: one byte plus its end-of-text mark.
  logic  in_full;
  byte_t in_byte;
  logic  in_end;

  // Result queue: entry 0 is the one on the output port; entries shift down
  // as each transaction completes.
  code_t res_code [MAX_RESULTS];
  logic  res_repl [MAX_RESULTS];
  cnt_t  res_cnt;
  logic  res_end;

  // Pending bytes of an incomplete sequence. The bytes carry no reset; only
  // entries below held_cnt are ever used.
  byte_t       held [2];
  logic [1:0]  held_cnt;

  logic out_take;
  logic fire;

  assign out_take = m_axis_tvalid && m_axis_tready;
  // The decode fires when the queue is empty or is handing over its last entry.
  assign fire = in_full && ((res_cnt == '0) || (res_cnt == cnt_t'(1) && m_axis_tready));
  assign s_axis_tready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_axis_tready) begin
      in_full <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_end  <= s_axis_tlast;
    end
  end

  // Decode. The working buffer is the pending bytes followed by the new byte.
  // At most three characters come out, each taking at least one byte, so the
  // scan is three short steps.
  byte_t       buf_b [3];
  logic [1:0]  buf_n;
  code_t       dec_code [MAX_RESULTS];
  logic        dec_repl [MAX_RESULTS];
  cnt_t        dec_cnt;
  logic [1:0]  held_cnt_next;
  byte_t       held_next [2];

  function automatic logic is_cont(input byte_t b);
    return (b & MASK_TOP2) == CONT_PAT;
  endfunction

  always_comb begin
    logic [1:0] pos;
    logic [1:0] avail;
    logic       stop;
    byte_t      w0;
    byte_t      w1;
    byte_t      w2;
    code_t      code;
    logic       repl;
    logic [1:0] use_n;
    logic       emit;

    buf_b[0] = (held_cnt == 2'd0) ? in_byte : held[0];
    buf_b[1] = (held_cnt == 2'd1) ? in_byte : held[1];
    buf_b[2] = in_byte;
    buf_n    = held_cnt + 2'd1;

    pos     = 2'd0;
    stop    = 1'b0;
    dec_cnt = '0;
    w0 = '0;
    w1 = '0;
    w2 = '0;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      dec_code[k] = '0;
      dec_repl[k] = 1'b0;
    end

    for (int k = 0; k < MAX_RESULTS; k++) begin
      unique case (pos)
        2'd0: begin
          w0 = buf_b[0]; w1 = buf_b[1]; w2 = buf_b[2];
        end
        2'd1: begin
          w0 = buf_b[1]; w1 = buf_b[2]; w2 = '0;
        end
        default: begin
          w0 = buf_b[2]; w1 = '0;       w2 = '0;
        end
      endcase
      avail = buf_n - pos;
      code  = '0;
      repl  = 1'b0;
      use_n = 2'd1;
      emit  = 1'b1;

      priority if (w0 < CONT_PAT) begin
        code = {8'h00, w0};
      end else if ((w0 & MASK_TOP3) == LEAD2_PAT) begin
        if (avail < 2'd2) begin
          emit = in_end;
          repl = 1'b1;
        end else if (is_cont(w1)) begin
          code  = {5'b0, w0[4:0] & LEAD2_BITS[4:0], w1[5:0] & CONT_BITS[5:0]};
          use_n = 2'd2;
        end else begin
          repl = 1'b1;
        end
      end else if ((w0 & MASK_TOP4) == LEAD3_PAT) begin
        if (avail < 2'd2) begin
          emit = in_end;
          repl = 1'b1;
        end else if (!is_cont(w1)) begin
          repl = 1'b1;
        end else if (avail < 2'd3) begin
          emit = in_end;
          repl = 1'b1;
        end else if (is_cont(w2)) begin
          code  = {w0[3:0] & LEAD3_BITS[3:0], w1[5:0] & CONT_BITS[5:0],
                   w2[5:0] & CONT_BITS[5:0]};
          use_n = 2'd3;
        end else begin
          repl = 1'b1;
        end
      end else begin
        repl = 1'b1;
      end

      // Code points beyond Latin-1 still consume their whole sequence.
      if (code > LATIN1_MAX) begin
        repl = 1'b1;
      end

      if (!stop && (pos < buf_n)) begin
        if (emit) begin
          dec_code[dec_cnt[1:0]] = repl ? repl_code : code;
          dec_repl[dec_cnt[1:0]] = repl;
          dec_cnt = dec_cnt + cnt_t'(1);
          pos     = pos + use_n;
        end else begin
          stop = 1'b1;
        end
      end
    end

    // Whatever was not consumed stays pending.
    held_cnt_next = buf_n - pos;
    unique case (pos)
      2'd0: begin
        held_next[0] = buf_b[0]; held_next[1] = buf_b[1];
      end
      2'd1: begin
        held_next[0] = buf_b[1]; held_next[1] = buf_b[2];
      end
      default: begin
        held_next[0] = buf_b[2]; held_next[1] = buf_b[2];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_cnt <= 2'd0;
    end else if (fire) begin
      held_cnt <= held_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      held[0] <= held_next[0];
      held[1] <= held_next[1];
    end
  end

  // Result queue control.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= '0;
    end else if (fire) begin
      res_cnt <= dec_cnt;
    end else if (out_take) begin
      res_cnt <= res_cnt - cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_end <= in_end;
      for (int k = 0; k < MAX_RESULTS; k++) begin
        res_code[k] <= dec_code[k];
        res_repl[k] <= dec_repl[k];
      end
    end else if (out_take) begin
      for (int k = 0; k < MAX_RESULTS - 1; k++) begin
        res_code[k] <= res_code[k+1];
        res_repl[k] <= res_repl[k+1];
      end
    end
  end

  // The entry on the port is the last of its byte when it is the only one left.
  assign m_axis_tvalid   = (res_cnt != '0);
  assign m_axis_tdata    = res_code[0];
  assign m_axis_tuser[0] = res_repl[0];
  assign m_axis_tuser[1] = (res_cnt == cnt_t'(1));
  assign m_axis_tlast    = (res_cnt == cnt_t'(1)) && res_end;

endmodule

`default_nettype wire

/* hdl/utf8l1_checker.sv */
// Port-level checker for the UTF-8 to Latin-1 decoder core, with its bind.
// Depends on utf8l1_pkg and on utf8_to_latin1_decoder_core.
`default_nettype none

module utf8l1_checker
  import utf8l1_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              s_axis_tready,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [CODE_W-1:0] m_axis_tdata,
  input wire logic [1:0]        m_axis_tuser,
  input wire logic              m_axis_tlast
);

  // A stalled result transaction keeps its valid and its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // The end of the text is always the last result of its byte.
  a_text_last_run_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])
    else $error("text_last without run_last");

  // The input only stalls behind pending results.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // Nothing is shown right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind utf8_to_latin1_decoder_core utf8l1_checker u_utf8l1_checker (.*);

`default_nettype wire

/* test/utf8l1_tb_pkg.sv */
// Scoreboard for the UTF-8 to Latin-1 decoder testbench: predicts decoded characters per byte.
// Depends on utf8l1_pkg for the byte masks, code width and reset replacement value.
package utf8l1_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8l1_pkg::*;

  typedef struct packed {
    code_t code;
    logic  replaced;
    logic  run_last;
    logic  text_last;
  } latin1_char_t;

  class latin1_tracker;
    byte_t        held[2];
    int           held_cnt;
    code_t        repl_code;
    latin1_char_t pending_chars[$];
    int unsigned  errors;
    int unsigned  bytes_seen;
    int unsigned  chars_seen;
    int unsigned  repl_seen;

    function new();
      held_cnt  = 0;
      repl_code = REPL_RESET;
      errors    = 0;
      bytes_seen = 0;
      chars_seen = 0;
      repl_seen  = 0;
    endfunction

    function void set_replacement(code_t value);
      repl_code = value;
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction

    function bit is_cont(byte_t b);
      return (b & MASK_TOP2) == CONT_PAT;
    endfunction

    // Decodes the held bytes plus the new one and queues the characters they yield.
    function void note_byte(byte_t b, logic eot);
      byte_t        pend[3];
      latin1_char_t found[3];
      int           n;
      int           pos;
      int           cnt;
      int           avail;
      int           span;
      byte_t        b0;
      logic [15:0]  cp;
      bit           bad;
      bit           stop;
      n = held_cnt;
      for (int k = 0; k < held_cnt; k++) pend[k] = held[k];
      pend[n] = b;
      n++;
      pos  = 0;
      cnt  = 0;
      stop = 0;
      bytes_seen++;
      while (pos < n && !stop) begin
        avail = n - pos;
        b0    = pend[pos];
        cp    = '0;
        bad   = 0;
        span  = 1;
        if (b0 < CONT_PAT) begin
          cp = {8'h00, b0};
        end else if ((b0 & MASK_TOP3) == LEAD2_PAT) begin
          if (avail < 2) begin
            if (!eot) stop = 1;
            else bad = 1;
          end else if (is_cont(pend[pos+1])) begin
            cp   = {5'b0, b0[4:0], pend[pos+1][5:0]};
            span = 2;
          end else begin
            bad = 1;
          end
        end else if ((b0 & MASK_TOP4) == LEAD3_PAT) begin
          if (avail < 2) begin
            if (!eot) stop = 1;
            else bad = 1;
          end else if (!is_cont(pend[pos+1])) begin
            bad = 1;
          end else if (avail < 3) begin
            if (!eot) stop = 1;
            else bad = 1;
          end else if (is_cont(pend[pos+2])) begin
            cp   = {b0[3:0], pend[pos+1][5:0], pend[pos+2][5:0]};
            span = 3;
          end else begin
            bad = 1;
          end
        end else begin
          bad = 1;
        end
        if (!stop) begin
          if (!bad && cp > LATIN1_MAX) bad = 1;
          found[cnt] = '{code: bad ? repl_code : cp, replaced: bad,
                         run_last: 1'b0, text_last: 1'b0};
          cnt++;
          pos += span;
        end
      end
      held_cnt = n - pos;
      for (int k = 0; k < held_cnt; k++) held[k] = pend[pos+k];
      if (cnt > 0) begin
        found[cnt-1].run_last  = 1'b1;
        found[cnt-1].text_last = eot;
      end
      for (int k = 0; k < cnt; k++) pending_chars.push_back(found[k]);
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      errors++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    endfunction

    // Compares one character leaving the block with the oldest prediction.
    function void check_char(code_t code, logic [1:0] user, logic last);
      latin1_char_t want;
      if (pending_chars.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected character, expected none, actual code 0x%0h",
                 $time, code);
        return;
      end
      want = pending_chars.pop_front();
      chars_seen++;
      if (want.replaced) repl_seen++;
      if (code !== want.code) report("code", want.code, code);
      if (user[0] !== want.replaced) report("was_replaced", want.replaced, user[0]);
      if (user[1] !== want.run_last) report("run_last", want.run_last, user[1]);
      if (last !== want.text_last) report("text_last", want.text_last, last);
    endfunction
  endclass

endpackage

/* test/tb_utf8_to_latin1_decoder_core.sv */
// Self-checking testbench for utf8_to_latin1_decoder_core.
// Depends on utf8l1_pkg (RTL) and utf8l1_tb_pkg (scoreboard); drives random UTF-8 text.
module tb_utf8_to_latin1_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8l1_pkg::*;
  import utf8l1_tb_pkg::*;

  // Every input of the block starts at a known value.
  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] in_byte
  logic        s_axis_tlast  = 1'b0;   // end_of_text
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [15:0] code
  logic [1:0]  m_axis_tuser;           // [0] was_replaced, [1] run_last
  logic        m_axis_tlast;           // text_last
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data      = 16'h0000;

  latin1_tracker tracker = new();

  // Random idling on both sides is enabled while this flag is set.
  bit          idle_on = 1'b1;
  int unsigned texts_sent = 0;
  int unsigned phase_bytes;
  byte_t       text_q[$];
  code_t       repl_settings[6];

  // Hand-picked sequences: zero byte, ASCII top, a Latin-1 pair, a pair above 0xFF,
  // an overlong triple that decodes to the reset replacement value as a genuine code,
  // a triple above 0xFF, a stray continuation, a 4-byte lead, a pair broken by ASCII,
  // a triple broken at its third byte (three characters out of one byte), 0xFF,
  // and two texts that end in the middle of a sequence. Bit 8 marks end of text.
  logic [8:0] directed_seq[23] = '{
    9'h000, 9'h07F, 9'h0C3, 9'h0A9, 9'h0C4, 9'h080, 9'h0E0, 9'h080, 9'h0BF,
    9'h0E2, 9'h082, 9'h0AC, 9'h080, 9'h0F0, 9'h0C3, 9'h041, 9'h0E2, 9'h082,
    9'h041, 9'h0FF, 9'h0E2, 9'h182, 9'h1C2
  };

  utf8_to_latin1_decoder_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // All three channels are observed at the rising edge. Inputs only move at the falling
  // edge, and the block's registered outputs have not yet updated when this block runs.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.set_replacement(cfg_data);
      if (s_axis_tvalid && s_axis_tready) tracker.note_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) tracker.check_char(m_axis_tdata, m_axis_tuser,
                                                             m_axis_tlast);
    end
  end

  // The receiver stalls in random bursts while idling is enabled.
  initial begin
    int stall_len;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_len = $urandom_range(1, 17);
        m_axis_tready <= 1'b0;
        repeat (stall_len) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Holds the byte valid until the block takes it. Valid is left high afterwards so the
  // next call can present a new byte without a bubble.
  task automatic send_byte(byte_t value, logic eot);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= eot;
    do @(posedge clk); while (!s_axis_tready);
    phase_bytes++;
  endtask

  task automatic sender_gap(int cycles);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'($urandom);
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic maybe_gap();
    if (idle_on && $urandom_range(0, 7) == 0) sender_gap($urandom_range(1, 17));
  endtask

  // Stops sending until every predicted character has come out, then waits on in case a byte
  // that yields nothing is still inside the block.
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_replacement(code_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic byte_t any_cont();
    return byte_t'($urandom_range(8'h80, 8'hBF));
  endfunction

  // A byte that is never a continuation byte; flipping bit 7 turns 10xxxxxx into 00xxxxxx.
  function automatic byte_t non_cont();
    byte_t b;
    b = byte_t'($urandom);
    if (b[7:6] == 2'b10) b[7] = 1'b0;
    return b;
  endfunction

  // Appends one character to text_q. Most are well formed with random content;
  // the rest are broken sequences, 4-byte forms and raw noise.
  function automatic void add_char();
    int    pick;
    byte_t lead;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      text_q.push_back(byte_t'($urandom_range(0, 127)));
    end else if (pick < 45) begin
      // Two-byte form that stays within Latin-1.
      text_q.push_back(byte_t'($urandom_range(8'hC2, 8'hC3)));
      text_q.push_back(any_cont());
    end else if (pick < 55) begin
      // Any two-byte lead, overlong and out-of-range forms included.
      text_q.push_back(byte_t'($urandom_range(8'hC0, 8'hDF)));
      text_q.push_back(any_cont());
    end else if (pick < 70) begin
      lead = byte_t'($urandom_range(8'hE0, 8'hEF));
      text_q.push_back(lead);
      // An overlong triple with a small second byte decodes to a Latin-1 code.
      if (lead == 8'hE0 || $urandom_range(0, 2) == 0) begin
        text_q[$] = 8'hE0;
        text_q.push_back(byte_t'($urandom_range(8'h80, 8'h83)));
      end else begin
        text_q.push_back(any_cont());
      end
      text_q.push_back(any_cont());
    end else if (pick < 77) begin
      text_q.push_back(byte_t'($urandom_range(8'hF0, 8'hFF)));
      repeat ($urandom_range(0, 3)) text_q.push_back(any_cont());
    end else if (pick < 90) begin
      // Broken sequence: a lead, maybe one continuation, then a byte that cannot follow.
      lead = byte_t'($urandom_range(8'hC0, 8'hEF));
      text_q.push_back(lead);
      if (lead >= 8'hE0 && $urandom_range(0, 1) == 1) text_q.push_back(any_cont());
      text_q.push_back(non_cont());
    end else begin
      text_q.push_back(byte_t'($urandom));
    end
  endfunction

  // Builds a text of roughly the given length and sends it, marking its last byte.
  // A text may end halfway through a sequence, which exercises the flush at its end.
  task automatic send_text(int target_len);
    text_q.delete();
    while (text_q.size() < target_len) add_char();
    if ($urandom_range(0, 5) == 0) text_q.push_back(byte_t'($urandom_range(8'hC0, 8'hEF)));
    for (int k = 0; k < text_q.size(); k++) begin
      maybe_gap();
      send_byte(text_q[k], k == text_q.size() - 1);
    end
    texts_sent++;
  endtask

  // Stimulus: directed bytes with the reset replacement value, then one phase of random
  // text per replacement setting. Settings change only with the block drained and no
  // bytes held, so the predictor and the block agree on when the new value applies.
  initial begin
    repl_settings = '{16'hFFFF, 16'h0000, 16'h0041, 16'h0000, 16'h00E9, REPL_RESET};
    repl_settings[3] = code_t'($urandom_range(0, 65535));
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    phase_bytes = 0;
    foreach (directed_seq[k]) begin
      maybe_gap();
      send_byte(directed_seq[k][7:0], directed_seq[k][8]);
    end

    foreach (repl_settings[p]) begin
      wait_drained();
      write_replacement(repl_settings[p]);
      // The last phase runs with both sides at full rate.
      idle_on = (p != $size(repl_settings) - 1);
      phase_bytes = 0;
      while (phase_bytes < 80) send_text($urandom_range(1, 12));
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d bytes in %0d random texts plus directed cases, %0d replacement",
             tracker.bytes_seen, texts_sent, $size(repl_settings));
    $display("settings; %0d characters checked, %0d of them replacements, %0d errors.",
             tracker.chars_seen, tracker.repl_seen, tracker.errors);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run of this stimulus.
  initial begin
    #5ms;
    $display("Timed out with %0d characters still expected.", tracker.pending());
    $display("status: fail");
    $finish;
  end

endmodule
